>>> hw/rtl/sscf_pkg.sv
// Shared types, constants and helpers for the case-folding substring matcher.
package sscf_pkg;

    // Pattern capacity default and character geometry
    localparam int PATTERN_MAX_DEF = 256;
    localparam int CHAR_W          = 8;
    localparam int NUM_CHARS       = 1 << CHAR_W;

    // ASCII upper-case range and the offset to lower case
    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [CHAR_W-1:0] FOLD_OFFSET = 8'h20;

    // Request kind
    typedef enum logic {
        ACT_PATTERN = 1'b0,
        ACT_SUBJECT = 1'b1
    } action_t;

    // Request held in the stage whose mask rows are being read out
    typedef struct packed {
        logic              vld;
        action_t           action;
        logic [CHAR_W-1:0] char_byte;
        logic              first;
        logic              last;
        logic              fold_hit;
    } stage_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        is_upper = (c >= UPPER_FIRST) && (c <= UPPER_LAST);
    endfunction

endpackage

>>> hw/rtl/sscf_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module sscf_ram
    import sscf_pkg::*;
#(
    parameter int WIDTH = PATTERN_MAX_DEF,
    parameter int DEPTH = NUM_CHARS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports, old data on a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> hw/rtl/sscf_mask_table.sv
// Per-character position mask table: row c has bit i set when pattern byte i equals c.
module sscf_mask_table
    import sscf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [CHAR_W-1:0]      rd_char,
    input  stage_t                 stage,
    input  logic                   adv,
    output logic [PATTERN_MAX-1:0] mask,
    output logic [LEN_W-1:0]       pat_len
);

    logic [NUM_CHARS-1:0]   row_vld_reg, row_vld_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   fwd_vld_reg;
    logic [CHAR_W-1:0]      fwd_addr_reg;
    logic [PATTERN_MAX-1:0] fwd_data_reg;

    logic [CHAR_W-1:0]      rd_fold_char;
    logic [CHAR_W-1:0]      addr_a, addr_b;
    logic [PATTERN_MAX-1:0] rd_data_a, rd_data_b;
    logic [PATTERN_MAX-1:0] row_a, row_b;
    logic                   pat_adv, room, wr_en;
    logic [LEN_W-1:0]       pos;
    logic [PATTERN_MAX-1:0] pos_bit, wr_data;
    logic [NUM_CHARS-1:0]   row_bit;

    assign rd_fold_char = rd_char + FOLD_OFFSET;
    assign addr_a       = stage.char_byte;
    assign addr_b       = stage.char_byte + FOLD_OFFSET;

    sscf_ram #(
        .WIDTH (PATTERN_MAX),
        .DEPTH (NUM_CHARS)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (addr_a),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_char),
        .rd_addr_b (rd_fold_char),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Rows: forward the last write (missed by a read in the same cycle), drop stale rows
    always_comb begin
        row_a = '0;
        row_b = '0;
        if (row_vld_reg[addr_a]) begin
            row_a = (fwd_vld_reg && fwd_addr_reg == addr_a) ? fwd_data_reg : rd_data_a;
        end
        if (row_vld_reg[addr_b]) begin
            row_b = (fwd_vld_reg && fwd_addr_reg == addr_b) ? fwd_data_reg : rd_data_b;
        end
        mask = row_a | (stage.fold_hit ? row_b : '0);
    end

    // Pattern append: set bit pos in the row of the pattern byte
    always_comb begin
        pat_adv      = adv && stage.vld && (stage.action == ACT_PATTERN);
        pos          = stage.first ? '0 : len_reg;
        room         = pos < LEN_W'(PATTERN_MAX);
        pos_bit      = PATTERN_MAX'(1) << pos;
        row_bit      = NUM_CHARS'(1) << addr_a;
        wr_en        = pat_adv && room;
        wr_data      = (stage.first ? '0 : row_a) | pos_bit;
        len_next     = len_reg;
        row_vld_next = row_vld_reg;
        if (wr_en) begin
            len_next     = pos + LEN_W'(1);
            row_vld_next = (stage.first ? '0 : row_vld_reg) | row_bit;
        end
    end

    assign pat_len = len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            len_reg     <= '0;
            fwd_vld_reg <= 1'b0;
        end else begin
            row_vld_reg <= row_vld_next;
            len_reg     <= len_next;
            if (wr_en) begin
                fwd_vld_reg <= 1'b1;
            end
        end
    end

    // Copy of the most recent write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= addr_a;
            fwd_data_reg <= wr_data;
        end
    end

endmodule

>>> hw/rtl/sscf_shift_and.sv
// Bit-parallel partial-match vector and found flag for the subject stream.
module sscf_shift_and
    import sscf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  stage_t                 stage,
    input  logic                   adv,
    input  logic [PATTERN_MAX-1:0] mask,
    input  logic [LEN_W-1:0]       pat_len,
    output logic                   found_next
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] part_reg, part_next;
    logic                   found_reg, found_upd;
    logic [PATTERN_MAX-1:0] part_base, part_new;
    logic                   found_base, hit;
    logic [IDX_W-1:0]       tail_idx;

    // Shift in a fresh start, keep positions whose byte matches
    always_comb begin
        part_base  = stage.first ? '0 : part_reg;
        found_base = stage.first ? 1'b0 : found_reg;
        part_new   = ((part_base << 1) | PATTERN_MAX'(1)) & mask;
        tail_idx   = IDX_W'(pat_len - LEN_W'(1));
        hit        = (pat_len != '0) && part_new[tail_idx];
        found_next = found_base | hit;
    end

    // Pattern loads and subject ends restart the search
    always_comb begin
        part_next = part_reg;
        found_upd = found_reg;
        if (adv && stage.vld) begin
            if (stage.action == ACT_SUBJECT && !stage.last) begin
                part_next = part_new;
                found_upd = found_next;
            end else begin
                part_next = '0;
                found_upd = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            part_reg  <= part_next;
            found_reg <= found_upd;
        end
    end

endmodule

>>> hw/rtl/substring_match_case_fold_core.sv
// Case-folding substring matcher: request stage, result register and assertions.
// A subject result is registered as the request leaves the request stage.
// Throughput: one request per cycle, set by the two-port mask table read and the
// shift-and update, while no result waits on m_ready; patterns give no result.
// Reset: synchronous, active low; clears pattern length, row valid bits, match
// state and result valid, and sets fold_case to 1. No clearing pass is needed.
module substring_match_case_fold_core
    import sscf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_wdata,
    // Requests
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [CHAR_W-1:0] s_char_byte,
    input  logic              s_first,
    input  logic              s_last,
    // Results
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic              m_subject_end
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                   fold_case_reg;
    stage_t                 stage_reg, stage_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg, m_subject_end_reg;
    logic                   adv, accept, out_load, found_next;
    logic [PATTERN_MAX-1:0] mask;
    logic [LEN_W-1:0]       pat_len;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_case_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            fold_case_reg <= cfg_wdata;
        end
    end

    // Stage advances unless it holds a result that cannot be stored
    assign adv      = !stage_reg.vld || (stage_reg.action == ACT_PATTERN) ||
                      !m_valid_reg || m_ready;
    assign s_ready  = adv;
    assign accept   = s_valid && s_ready;
    assign out_load = adv && stage_reg.vld && (stage_reg.action == ACT_SUBJECT);

    always_comb begin
        stage_next = stage_reg;
        if (accept) begin
            stage_next.vld       = 1'b1;
            stage_next.action    = action_t'(s_action);
            stage_next.char_byte = s_char_byte;
            stage_next.first     = s_first;
            stage_next.last      = s_last;
            stage_next.fold_hit  = fold_case_reg && is_upper(s_char_byte);
        end else if (adv) begin
            stage_next.vld = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= stage_next;
        end
    end

    sscf_mask_table #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_mask_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_char (s_char_byte),
        .stage   (stage_reg),
        .adv     (adv),
        .mask    (mask),
        .pat_len (pat_len)
    );

    sscf_shift_and #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_shift_and (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stage      (stage_reg),
        .adv        (adv),
        .mask       (mask),
        .pat_len    (pat_len),
        .found_next (found_next)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg       <= found_next;
            m_subject_end_reg <= stage_reg.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_subject_end = m_subject_end_reg;

`ifndef ASSERT_OFF
    // A stalled subject request keeps its contents
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg.vld && !adv |=> stage_reg.vld && $stable(stage_reg))
        else $error("stalled request changed");

    // Every accepted request lands in the stage
    a_accept_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> stage_reg.vld && stage_reg.char_byte == $past(s_char_byte))
        else $error("accepted request lost");

    // A subject request leaving the stage yields a result
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && m_subject_end == $past(stage_reg.last))
        else $error("result missing after subject request");

    // Pattern length never passes capacity
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && stage_reg.vld && stage_reg.action == ACT_PATTERN
            |=> pat_len <= LEN_W'(PATTERN_MAX) && pat_len != '0)
        else $error("pattern length out of range");
`endif

endmodule
